// ===== rtl/bvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvt_pkg: shared types and constants
// Opcodes, actions and fixed values of the scheduler table.
// ----------------------------------------------------------------------------
package bvt_pkg;

	// table size; the slot and chosen_slot ports carry 4 bits
	localparam int SLOTS = 16;

	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_WAKE     = 3'd1,
		OP_SLEEP    = 3'd2,
		OP_SCHEDULE = 3'd3,
		OP_ADJUST   = 3'd4,
		OP_READ     = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_RESCHED  = 2'd1,
		ACT_DEADLINE = 2'd2,
		ACT_CHOSEN   = 2'd3
	} action_t;

	localparam logic [31:0] OVERRUN_MARK   = 32'hf000_0000;
	localparam logic [31:0] REBASE_STEP    = 32'he000_0000;
	localparam logic [31:0] ALL_ONES32     = 32'hffff_ffff;
	localparam logic [31:0] DEFAULT_WEIGHT = 32'd10;
	localparam logic [30:0] SLICE_MAX      = 31'h7fff_ffff;
	localparam logic [30:0] CTX_RESET      = 31'd5000000;
	localparam logic [30:0] UNIT_RESET     = 31'd100000;

	localparam logic [0:0] REG_CTX  = 1'b0;
	localparam logic [0:0] REG_UNIT = 1'b1;

endpackage

// ===== rtl/bvt_scheduler_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvt_scheduler_table: borrowed virtual time scheduler table
// Slot table, charge/scan sequencer and one shared restoring divider.
// ----------------------------------------------------------------------------
// One item at a time. Add, sleep, adjust, read and unused opcodes pass from
// the execute state straight to the output state, as does a wake of a slot
// that is already queued. Any other wake runs the 32-step charging division
// first and then asks for a reschedule or goes on to the 32-step weight
// division to check the deadline. A schedule runs the charge division, a scan
// of all SLOTS slots at one slot per cycle, a rebase pass and the 32-step
// slice division. The single radix-2 divider, one quotient bit a cycle, and
// the one-slot-a-cycle scan share the sequencer. The slot table lives in
// flip-flops; the rebase pass updates all slots but slot 0 at once. in_stall is
// high from transfer until the result is taken; the result sits in an output
// register, and the next transfer can land the cycle after it is taken.
// ----------------------------------------------------------------------------
module bvt_scheduler_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [3:0]  slot,
	input  logic [62:0] now,
	input  logic        runnable,
	input  logic        migrated,
	input  logic [31:0] weight,
	input  logic signed [31:0] warp_offset,
	input  logic        warp_back,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [1:0]  action,
	output logic [3:0]  chosen_slot,
	output logic [30:0] slice_length,
	output logic [63:0] timer_deadline,
	output logic [31:0] read_weight,
	output logic signed [31:0] read_warp_offset,
	output logic        read_warp_back
);

	localparam int SLOTS = bvt_pkg::SLOTS;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_CHG, S_CHG_DONE, S_SCAN, S_REBASE, S_SLICE,
		S_WAKE1, S_WAKE2, S_WDIV, S_WEND, S_OUT
	} state_t;

	state_t state_q;

	// config
	logic [30:0] ctx_q, unit_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q  <= bvt_pkg::CTX_RESET;
			unit_q <= bvt_pkg::UNIT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == bvt_pkg::REG_CTX) ctx_q <= pwdata[30:0];
			else if (paddr[2] == bvt_pkg::REG_UNIT) unit_q <= pwdata[30:0];
		end
	end
	always_comb begin
		prdata = 32'd0;
		if (paddr == 3'd0) prdata = {1'b0, ctx_q};
		else if (paddr == 3'd4) prdata = {1'b0, unit_q};
	end

	// slot table
	logic        queued_q [SLOTS];
	logic [31:0] avt_q [SLOTS];
	logic [31:0] evt_q [SLOTS];
	logic [31:0] wgt_q [SLOTS];
	logic        warped_q [SLOTS];
	logic [31:0] wofs_q [SLOTS];
	logic        wback_q [SLOTS];
	logic [31:0] svt_q;
	logic [SW-1:0] run_q;
	logic [63:0] start_q, dl_q;

	// latched item
	logic [2:0]  op_q;
	logic [3:0]  slot_q;
	logic [62:0] now_q;
	logic        runn_q, migr_q, wb_q;
	logic [31:0] w_q, wo_q;

	// shared divider: quo_q / den_q, 32-bit quotient, 33-bit remainder path
	logic [32:0] rem_q;
	logic [31:0] quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        dround_q; // charging division rounds up
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	assign rem_sh  = {rem_q[31:0], quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// scan
	logic [SW:0]   idx_q;
	logic [SW-1:0] next_q, nprime_q;
	logic [31:0]   nevt_q, pevt_q, minavt_q;
	logic          haveprime_q;
	logic [31:0]   cur_evt_q;

	logic [SW-1:0] sidx;
	logic          slot_ok;
	assign sidx = idx_q[SW-1:0];
	assign slot_ok = ({28'd0, slot_q} < 32'(SLOTS));
	logic [SW-1:0] s_q;
	assign s_q = SW'(slot_q);

	logic [31:0] ran32;
	assign ran32 = now_q[31:0] - start_q[31:0];

	// charged quotient, with round-up
	logic [31:0] charged_units;
	assign charged_units = quo_q + {31'd0, (rem_q != 33'd0) && dround_q};

	logic        out_fire;
	assign out_fire = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid;

	function automatic logic [31:0] eff(input logic w, input logic [31:0] a,
		input logic [31:0] o);
		eff = w ? a - o : a;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				queued_q[i] <= (i == 0);
				avt_q[i]    <= (i == 0) ? bvt_pkg::ALL_ONES32 : 32'd0;
				evt_q[i]    <= (i == 0) ? bvt_pkg::ALL_ONES32 : 32'd0;
				wgt_q[i]    <= bvt_pkg::DEFAULT_WEIGHT;
				warped_q[i] <= 1'b0;
				wofs_q[i]   <= 32'd0;
				wback_q[i]  <= 1'b0;
			end
			svt_q   <= 32'd0;
			run_q   <= '0;
			start_q <= 64'd0;
			dl_q    <= '1;
			status <= 1'b0; action <= bvt_pkg::ACT_NONE;
			chosen_slot <= 4'd0; slice_length <= 31'd0;
			timer_deadline <= 64'd0; read_weight <= 32'd0;
			read_warp_offset <= 32'sd0; read_warp_back <= 1'b0;
			op_q <= 3'd0; slot_q <= 4'd0; now_q <= 63'd0;
			runn_q <= 1'b0; migr_q <= 1'b0; wb_q <= 1'b0;
			w_q <= 32'd0; wo_q <= 32'd0;
			rem_q <= 33'd0; quo_q <= 32'd0; den_q <= 32'd1;
			cnt_q <= 6'd0; dround_q <= 1'b0;
			idx_q <= '0; next_q <= '0; nprime_q <= '0;
			nevt_q <= 32'd0; pevt_q <= 32'd0; minavt_q <= 32'd0;
			haveprime_q <= 1'b0; cur_evt_q <= 32'd0;
		end else begin
			unique case (state_q)
			S_IDLE: begin
				if (out_fire) out_valid <= 1'b0;
				else if (in_valid && !in_stall) begin
					op_q <= opcode; slot_q <= slot; now_q <= now;
					runn_q <= runnable; migr_q <= migrated;
					w_q <= weight; wo_q <= warp_offset; wb_q <= warp_back;
					status <= 1'b0; action <= bvt_pkg::ACT_NONE;
					chosen_slot <= 4'd0; slice_length <= 31'd0;
					timer_deadline <= 64'd0; read_weight <= 32'd0;
					read_warp_offset <= 32'sd0; read_warp_back <= 1'b0;
					state_q <= S_EXEC;
				end
			end
			S_EXEC: begin
				// start charge division (schedule or wake)
				rem_q <= 33'd0; quo_q <= ran32;
				den_q <= (unit_q == 31'd0) ? 32'd1 : {1'b0, unit_q};
				cnt_q <= 6'd32; dround_q <= 1'b1;
				if (op_q == bvt_pkg::OP_SCHEDULE ||
					(slot_ok && op_q == bvt_pkg::OP_WAKE && !queued_q[s_q])) begin
					state_q <= S_CHG;
				end else begin
					state_q <= S_OUT;
				end
				if (op_q != bvt_pkg::OP_SCHEDULE && slot_ok) begin
					unique case (op_q)
					bvt_pkg::OP_ADD: begin
						wgt_q[s_q] <= bvt_pkg::DEFAULT_WEIGHT;
						wback_q[s_q] <= 1'b0; warped_q[s_q] <= 1'b0;
						wofs_q[s_q] <= 32'd0;
						avt_q[s_q] <= (slot_q == 4'd0) ? bvt_pkg::ALL_ONES32 : svt_q;
						evt_q[s_q] <= (slot_q == 4'd0) ? bvt_pkg::ALL_ONES32 : svt_q;
					end
					bvt_pkg::OP_WAKE: begin
						timer_deadline <= dl_q;
						if (!queued_q[s_q]) begin
							queued_q[s_q] <= 1'b1;
							if (avt_q[s_q] < svt_q || migr_q) begin
								avt_q[s_q] <= svt_q;
								evt_q[s_q] <= eff(warped_q[s_q], svt_q, wofs_q[s_q]);
							end else begin
								evt_q[s_q] <= eff(warped_q[s_q], avt_q[s_q], wofs_q[s_q]);
							end
						end
					end
					bvt_pkg::OP_SLEEP: begin
						if (s_q == run_q) action <= bvt_pkg::ACT_RESCHED;
						else queued_q[s_q] <= 1'b0;
					end
					bvt_pkg::OP_ADJUST: begin
						if (w_q == 32'd0) status <= 1'b1;
						else begin
							wgt_q[s_q] <= w_q; wback_q[s_q] <= wb_q;
							warped_q[s_q] <= 1'b1; wofs_q[s_q] <= wo_q;
						end
					end
					bvt_pkg::OP_READ: begin
						read_weight <= wgt_q[s_q];
						read_warp_offset <= wofs_q[s_q];
						read_warp_back <= wback_q[s_q];
					end
					default: ;
					endcase
				end
			end
			S_CHG: begin
				// one restoring division step per cycle
				if (!rem_sub[32]) begin
					rem_q <= rem_sub; quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh; quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) state_q <= S_CHG_DONE;
			end
			S_CHG_DONE: begin
				if (op_q == bvt_pkg::OP_SCHEDULE) begin
					if (run_q != '0) begin
						avt_q[run_q] <= avt_q[run_q] + charged_units;
						evt_q[run_q] <= eff(warped_q[run_q], avt_q[run_q] + charged_units,
							wofs_q[run_q]);
						queued_q[run_q] <= runn_q;
					end
					idx_q <= '0; next_q <= '0; nprime_q <= '0;
					nevt_q <= bvt_pkg::ALL_ONES32; pevt_q <= bvt_pkg::ALL_ONES32;
					minavt_q <= bvt_pkg::ALL_ONES32; haveprime_q <= 1'b0;
					state_q <= S_SCAN;
				end else begin
					cur_evt_q <= eff(warped_q[run_q], avt_q[run_q] + charged_units,
						wofs_q[run_q]);
					state_q <= S_WAKE1;
				end
			end
			S_SCAN: begin
				if (queued_q[sidx]) begin
					if (evt_q[sidx] < nevt_q) begin
						nprime_q <= next_q; pevt_q <= nevt_q; haveprime_q <= 1'b1;
						next_q <= sidx; nevt_q <= evt_q[sidx];
					end else if (pevt_q == bvt_pkg::ALL_ONES32 || evt_q[sidx] < pevt_q) begin
						nprime_q <= sidx; pevt_q <= evt_q[sidx]; haveprime_q <= 1'b1;
					end
					if (avt_q[sidx] < minavt_q) minavt_q <= avt_q[sidx];
				end
				idx_q <= idx_q + (SW+1)'(1);
				if (idx_q == (SW+1)'(SLOTS - 1)) state_q <= S_REBASE;
			end
			S_REBASE: begin
				logic [31:0] sv;
				sv = (minavt_q != bvt_pkg::ALL_ONES32) ? minavt_q : svt_q;
				if (sv >= bvt_pkg::OVERRUN_MARK) begin
					for (int i = 1; i < SLOTS; i++) begin
						avt_q[i] <= avt_q[i] - bvt_pkg::REBASE_STEP;
						evt_q[i] <= evt_q[i] - bvt_pkg::REBASE_STEP;
					end
					svt_q <= sv - bvt_pkg::REBASE_STEP;
				end else svt_q <= sv;
				// slice divide uses pre-rebase difference (rebase cancels out)
				rem_q <= 33'd0; quo_q <= evt_q[nprime_q] - evt_q[next_q];
				den_q <= (wgt_q[next_q] == 32'd0) ? 32'd1 : wgt_q[next_q];
				cnt_q <= 6'd32; dround_q <= 1'b0;
				state_q <= S_SLICE;
			end
			S_SLICE: begin
				logic [63:0] slice64;
				if (cnt_q != 6'd0) begin
					if (!rem_sub[32]) begin
						rem_q <= rem_sub; quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh; quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
				end else begin
					if (next_q == '0) slice64 = {33'd0, ctx_q};
					else if (!haveprime_q || nprime_q == '0)
						slice64 = {30'd0, ctx_q, 3'd0} + {32'd0, ctx_q, 1'b0}; // x10
					else slice64 = {32'd0, quo_q} + {33'd0, ctx_q};
					if (slice64 > {33'd0, bvt_pkg::SLICE_MAX})
						slice64 = {33'd0, bvt_pkg::SLICE_MAX};
					run_q <= next_q;
					start_q <= {1'b0, now_q};
					dl_q <= {1'b0, now_q} + slice64;
					action <= bvt_pkg::ACT_CHOSEN;
					chosen_slot <= 4'(next_q);
					slice_length <= slice64[30:0];
					timer_deadline <= {1'b0, now_q} + slice64;
					state_q <= S_OUT;
				end
			end
			S_WAKE1: begin
				if (run_q == '0 || evt_q[s_q] <= cur_evt_q) begin
					action <= bvt_pkg::ACT_RESCHED;
					state_q <= S_OUT;
				end else begin
					rem_q <= 33'd0; quo_q <= evt_q[s_q] - cur_evt_q;
					den_q <= (wgt_q[run_q] == 32'd0) ? 32'd1 : wgt_q[run_q];
					cnt_q <= 6'd32; dround_q <= 1'b0;
					state_q <= S_WDIV;
				end
			end
			S_WDIV: begin
				if (!rem_sub[32]) begin
					rem_q <= rem_sub; quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh; quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) state_q <= S_WAKE2;
			end
			S_WAKE2: begin
				logic [63:0] slice64;
				slice64 = start_q + {32'd0, quo_q} + {33'd0, ctx_q};
				if (dl_q > slice64) begin
					dl_q <= slice64;
					action <= bvt_pkg::ACT_DEADLINE;
					timer_deadline <= slice64;
				end
				state_q <= S_WEND;
			end
			S_WEND: state_q <= S_OUT;
			S_OUT: begin
				out_valid <= 1'b1;
				state_q <= S_IDLE;
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("busy without stall");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result waits");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(action) && $stable(status) &&
		$stable(timer_deadline) && $stable(read_weight)))
		else $error("result changed while stalled");
	a_chosen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == bvt_pkg::ACT_CHOSEN) |-> (status == 1'b0))
		else $error("chosen with status");

endmodule

// ===== dv/bvt_scheduler_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvt_scheduler_table_tb: self-checking bench for the BVT scheduler table
// A directed table followed by random task traffic (add, wake, sleep,
// schedule, adjust, read, unused codes), under several register settings.
// A model of the slot table predicts the results; some directed rows carry their own.
// ----------------------------------------------------------------------------
module bvt_scheduler_table_tb;

	localparam int NSLOT      = bvt_pkg::SLOTS;
	localparam int WDOG_LIMIT = 5000;  // idle cycles before the watchdog ends the run
	localparam int DRAIN_WAIT = 120;   // cycles after the last result
	localparam int HOLD_LEN   = 400;   // long receiver hold-off

	typedef struct {
		logic [2:0]  op;
		logic [3:0]  sl;
		logic [62:0] tm;
		logic        run;
		logic        mig;
		logic [31:0] w;
		logic [31:0] wo;
		logic        wb;
	} task_req_t;

	typedef struct {
		logic        status;
		logic [1:0]  action;
		logic [3:0]  chosen;
		logic [30:0] slice;
		logic [63:0] deadline;
		logic [31:0] rw;
		logic [31:0] rwo;
		logic        rwb;
	} sched_res_t;

	// DUT ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [3:0]  slot = '0;
	logic [62:0] now = '0;
	logic        runnable = 1'b0, migrated = 1'b0;
	logic [31:0] weight = '0;
	logic signed [31:0] warp_offset = '0;
	logic        warp_back = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [1:0]  action;
	logic [3:0]  chosen_slot;
	logic [30:0] slice_length;
	logic [63:0] timer_deadline;
	logic [31:0] read_weight;
	logic signed [31:0] read_warp_offset;
	logic        read_warp_back;

	bvt_scheduler_table dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model
	// Shadow copy of the slot table and registers.
	logic        m_queued [NSLOT];
	logic [31:0] m_avt    [NSLOT];
	logic [31:0] m_evt    [NSLOT];
	logic [31:0] m_wgt    [NSLOT];
	logic        m_warped [NSLOT];
	logic [31:0] m_woff   [NSLOT];
	logic        m_wback  [NSLOT];
	logic [31:0] m_svt;
	logic [3:0]  m_cur;
	logic [63:0] m_start;
	logic [63:0] m_deadline;
	logic [30:0] m_ctx;
	logic [30:0] m_unit;

	sched_res_t pending_q[$];   // results still owed by the block
	int         errors = 0;
	bit         hold_req = 1'b0;
	int         idle_cnt = 0;
	logic [62:0] clock_ns = '0; // running system time for well-formed traffic

	task automatic table_reset();
		for (int i = 0; i < NSLOT; i++) begin
			m_queued[i] = (i == 0);
			m_avt[i]    = (i == 0) ? bvt_pkg::ALL_ONES32 : 32'd0;
			m_evt[i]    = m_avt[i];
			m_wgt[i]    = bvt_pkg::DEFAULT_WEIGHT;
			m_warped[i] = 1'b0;
			m_woff[i]   = '0;
			m_wback[i]  = 1'b0;
		end
		m_svt      = '0;
		m_cur      = '0;
		m_start    = '0;
		m_deadline = '1;
		m_ctx      = bvt_pkg::CTX_RESET;
		m_unit     = bvt_pkg::UNIT_RESET;
	endtask

	// vtime of slot s after being charged for the time run up to t
	function automatic logic [31:0] charged_vtime(int s, logic [62:0] t);
		logic [31:0] ran32;
		logic [63:0] ran, u, units;
		ran32 = 32'({1'b0, t} - m_start);
		ran   = {32'd0, ran32};
		u     = (m_unit != 0) ? {33'd0, m_unit} : 64'd1;
		units = (ran + u - 64'd1) / u;
		return m_avt[s] + units[31:0];
	endfunction

	function automatic logic [31:0] warp_adj(int s, logic [31:0] a);
		return m_warped[s] ? a - m_woff[s] : a;
	endfunction

	function automatic logic [31:0] per_weight(logic [31:0] diff, int s);
		logic [31:0] w;
		w = (m_wgt[s] != 0) ? m_wgt[s] : 32'd1;
		return diff / w;
	endfunction

	function automatic sched_res_t run_schedule(logic [62:0] t, logic keep);
		sched_res_t  r;
		int          prev, nxt, npr;
		logic [31:0] nxt_e, pr_e, min_a, e;
		logic        have_pr;
		logic [63:0] sl;
		r = '{default: '0};
		prev = m_cur; nxt = 0; npr = 0;
		nxt_e = bvt_pkg::ALL_ONES32; pr_e = bvt_pkg::ALL_ONES32;
		min_a = bvt_pkg::ALL_ONES32;
		have_pr = 1'b0;
		if (prev != 0) begin
			m_avt[prev]    = charged_vtime(prev, t);
			m_evt[prev]    = warp_adj(prev, m_avt[prev]);
			m_queued[prev] = keep;
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (m_queued[i]) begin
				e = m_evt[i];
				if (e < nxt_e) begin
					npr = nxt; pr_e = nxt_e; have_pr = 1'b1;
					nxt = i; nxt_e = e;
				end else if (pr_e == bvt_pkg::ALL_ONES32 || e < pr_e) begin
					npr = i; pr_e = e; have_pr = 1'b1;
				end
				if (m_avt[i] < min_a) min_a = m_avt[i];
			end
		end
		if (min_a != bvt_pkg::ALL_ONES32) m_svt = min_a;
		// overrun: rebase everyone but the idle slot
		if (m_svt >= bvt_pkg::OVERRUN_MARK) begin
			for (int i = 1; i < NSLOT; i++) begin
				m_avt[i] -= bvt_pkg::REBASE_STEP;
				m_evt[i] -= bvt_pkg::REBASE_STEP;
			end
			m_svt -= bvt_pkg::REBASE_STEP;
		end
		if (nxt == 0)
			sl = {33'd0, m_ctx};
		else if (!have_pr || npr == 0)
			sl = 64'd10 * {33'd0, m_ctx};
		else
			sl = {32'd0, per_weight(m_evt[npr] - m_evt[nxt], nxt)} + {33'd0, m_ctx};
		if (sl > {33'd0, bvt_pkg::SLICE_MAX}) sl = {33'd0, bvt_pkg::SLICE_MAX};
		m_cur      = 4'(nxt);
		m_start    = {1'b0, t};
		m_deadline = {1'b0, t} + sl;
		r.action   = bvt_pkg::ACT_CHOSEN;
		r.chosen   = 4'(nxt);
		r.slice    = sl[30:0];
		r.deadline = m_deadline;
		return r;
	endfunction

	function automatic sched_res_t run_wake(int s, logic [62:0] t, logic mig);
		sched_res_t  r;
		int          c;
		logic [31:0] c_e;
		logic [63:0] rt;
		r = '{default: '0};
		c = m_cur;
		r.deadline = m_deadline;
		if (m_queued[s]) return r;
		m_queued[s] = 1'b1;
		if (m_avt[s] < m_svt || mig) m_avt[s] = m_svt;
		m_evt[s] = warp_adj(s, m_avt[s]);
		c_e = warp_adj(c, charged_vtime(c, t));
		if (c == 0 || m_evt[s] <= c_e) begin
			r.action = bvt_pkg::ACT_RESCHED;
			return r;
		end
		rt = m_start + {32'd0, per_weight(m_evt[s] - c_e, c)} + {33'd0, m_ctx};
		if (m_deadline > rt) begin
			m_deadline = rt;
			r.action   = bvt_pkg::ACT_DEADLINE;
			r.deadline = rt;
		end
		return r;
	endfunction

	function automatic sched_res_t predict_outcome(task_req_t q);
		sched_res_t r;
		int         s;
		r = '{default: '0};
		s = q.sl;
		case (q.op)
			bvt_pkg::OP_SCHEDULE: r = run_schedule(q.tm, q.run);
			bvt_pkg::OP_ADD: begin
				m_wgt[s]    = bvt_pkg::DEFAULT_WEIGHT;
				m_wback[s]  = 1'b0;
				m_warped[s] = 1'b0;
				m_woff[s]   = '0;
				m_avt[s]    = (s == 0) ? bvt_pkg::ALL_ONES32 : m_svt;
				m_evt[s]    = m_avt[s];
			end
			bvt_pkg::OP_WAKE: r = run_wake(s, q.tm, q.mig);
			bvt_pkg::OP_SLEEP: begin
				if (q.sl == m_cur) r.action = bvt_pkg::ACT_RESCHED;
				else m_queued[s] = 1'b0;
			end
			bvt_pkg::OP_ADJUST: begin
				if (q.w == 0) begin
					r.status = 1'b1;
				end else begin
					m_wgt[s]    = q.w;
					m_wback[s]  = q.wb;
					m_warped[s] = 1'b1;
					m_woff[s]   = q.wo;
				end
			end
			bvt_pkg::OP_READ: begin
				r.rw  = m_wgt[s];
				r.rwo = m_woff[s];
				r.rwb = m_wback[s];
			end
			default: ;  // unused code: no effect, all-zero result
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers
	// Sender: drive one transfer, wait for it, then an optional gap.
	task automatic send_req(task_req_t q, bit typed, sched_res_t typed_exp);
		sched_res_t p;
		int         gap, r;
		in_valid    <= 1'b1;
		opcode      <= q.op;
		slot        <= q.sl;
		now         <= q.tm;
		runnable    <= q.run;
		migrated    <= q.mig;
		weight      <= q.w;
		warp_offset <= q.wo;
		warp_back   <= q.wb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = predict_outcome(q);
		pending_q.push_back(typed ? typed_exp : p);
		r = $urandom_range(0, 9);
		gap = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 50);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic reg_write(logic [0:0] idx, logic [30:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {1'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == bvt_pkg::REG_CTX) m_ctx = val;
		else m_unit = val;
	endtask

	// Block is idle only once every result is back and the sequencer is done.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- receiver
	always begin
		int r;
		@(posedge clk);
		if (hold_req) begin
			out_stall <= 1'b1;
			repeat (HOLD_LEN) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (r < 9) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- checker
	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0h, got %0h", e.status, status);
					errors++;
				end
				if (action !== e.action) begin
					$error("action: expected %0h, got %0h", e.action, action);
					errors++;
				end
				if (chosen_slot !== e.chosen) begin
					$error("chosen_slot: expected %0d, got %0d", e.chosen, chosen_slot);
					errors++;
				end
				if (slice_length !== e.slice) begin
					$error("slice_length: expected %0d, got %0d", e.slice, slice_length);
					errors++;
				end
				if (timer_deadline !== e.deadline) begin
					$error("timer_deadline: expected %0h, got %0h", e.deadline,
						timer_deadline);
					errors++;
				end
				if (read_weight !== e.rw) begin
					$error("read_weight: expected %0h, got %0h", e.rw, read_weight);
					errors++;
				end
				if (read_warp_offset !== e.rwo) begin
					$error("read_warp_offset: expected %0h, got %0h", e.rwo,
						read_warp_offset);
					errors++;
				end
				if (read_warp_back !== e.rwb) begin
					$error("read_warp_back: expected %0h, got %0h", e.rwb,
						read_warp_back);
					errors++;
				end
			end
		end
	end

	// Watchdog: any transfer on either channel or the register port resets it.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	task_req_t  dir_req [$];
	bit         dir_typed [$];
	sched_res_t dir_exp [$];

	task automatic add_row(logic [2:0] op, logic [3:0] sl, logic [62:0] tm, logic run,
			logic mig, logic [31:0] w, logic [31:0] wo, logic wb, bit typed,
			logic st, logic [31:0] rw, logic [31:0] rwo, logic rwb);
		task_req_t  q;
		sched_res_t e;
		q = '{op, sl, tm, run, mig, w, wo, wb};
		e = '{default: '0};
		e.status = st; e.rw = rw; e.rwo = rwo; e.rwb = rwb;
		dir_req.push_back(q);
		dir_typed.push_back(typed);
		dir_exp.push_back(e);
	endtask

	// Mostly well-formed traffic on a rising clock; now and then a wild time.
	function automatic task_req_t random_req();
		task_req_t q;
		int        r;
		q.sl  = $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 6));
		q.run = 1'($urandom_range(0, 1));
		q.mig = $urandom_range(0, 3) == 0;
		q.wb  = 1'($urandom_range(0, 1));
		q.w   = $urandom_range(0, 7) == 0 ? $urandom() : 32'($urandom_range(0, 64));
		q.wo  = $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 400)) - 32'd200;
		if ($urandom_range(0, 39) == 0) begin
			clock_ns = 63'({$urandom(), $urandom()});
		end else begin
			clock_ns = clock_ns + 63'($urandom_range(0, 20000000));
		end
		q.tm = clock_ns;
		r = $urandom_range(0, 99);
		if (r < 10)      q.op = bvt_pkg::OP_ADD;
		else if (r < 35) q.op = bvt_pkg::OP_WAKE;
		else if (r < 50) q.op = bvt_pkg::OP_SLEEP;
		else if (r < 80) q.op = bvt_pkg::OP_SCHEDULE;
		else if (r < 90) q.op = bvt_pkg::OP_ADJUST;
		else if (r < 97) q.op = bvt_pkg::OP_READ;
		else             q.op = 3'($urandom_range(6, 7));
		return q;
	endfunction

	initial begin
		logic [30:0] ctx_set  [4];
		logic [30:0] unit_set [4];
		task_req_t   q;

		table_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset, extremes of fields, every opcode, unused codes,
		// rejected adjust, wake of a queued slot, sleep of the running slot
		add_row(bvt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, bvt_pkg::DEFAULT_WEIGHT, 0, 0);
		add_row(bvt_pkg::OP_ADJUST, 3, 0, 0, 0, 0, 32'h7fffffff, 1, 1, 1, 0, 0, 0);
		add_row(3'd6, 15, '1, 1, 1, '1, '1, 1, 1, 0, 0, 0, 0);
		add_row(3'd7, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_ADD, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_ADJUST, 1, 0, 0, 0, '1, 32'h80000000, 1, 1, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 1, 0, '1, 32'h80000000, 1);
		add_row(bvt_pkg::OP_WAKE, 1, 1000, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_WAKE, 0, 1500, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_SCHEDULE, 0, 2000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_ADD, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_WAKE, 2, 3000000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_SLEEP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_SCHEDULE, 0, 9000000, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_ADJUST, 15, 0, 0, 0, 1, 32'h7fffffff, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_ADD, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_WAKE, 15, 12000000, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_SCHEDULE, 0, 63'h7fffffffffffffff, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_SLEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_SCHEDULE, 0, 63'h7fffffffffffffff, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(bvt_pkg::OP_READ, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < dir_req.size(); i++)
			send_req(dir_req[i], dir_typed[i], dir_exp[i]);
		drain();

		// register settings: reset values, both extremes, then random
		ctx_set[0]  = bvt_pkg::CTX_RESET;   unit_set[0] = bvt_pkg::UNIT_RESET;
		ctx_set[1]  = 31'd0;                unit_set[1] = 31'd1;
		ctx_set[2]  = bvt_pkg::SLICE_MAX;   unit_set[2] = bvt_pkg::SLICE_MAX;
		ctx_set[3]  = 31'($urandom_range(0, 20000000));
		unit_set[3] = 31'($urandom_range(1, 1000000));
		clock_ns = '0;
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(bvt_pkg::REG_CTX, ctx_set[ph]);
			reg_write(bvt_pkg::REG_UNIT, unit_set[ph]);
			for (int n = 0; n < 258; n++) begin
				// long receiver hold-off while the sender keeps offering
				if (ph == 1 && n == 100) hold_req = 1'b1;
				q = random_req();
				send_req(q, 1'b0, '{default: '0});
			end
			drain();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== bvt_scheduler_table.f =====
rtl/bvt_pkg.sv
rtl/bvt_scheduler_table.sv
dv/bvt_scheduler_table_tb.sv
